@@ hw/rtl/spq_pkg.sv @@
package spq_pkg;

  localparam int unsigned KEY_W           = 24;
  localparam int unsigned TAG_W           = 16;
  localparam int unsigned MODE_W          = 2;
  localparam int unsigned STATUS_W        = 2;
  localparam int unsigned COUNT_OUT_W     = 7;
  localparam int unsigned QUEUE_DEPTH_DEF = 64;

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_CLEAR  = 2'd2
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } entry_t;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic ins;
    logic rem;
  } cell_ctrl_t;

endpackage

@@ hw/rtl/spq_cell.sv @@
module spq_cell (
  input  logic                clk_i,
  input  spq_pkg::cell_ctrl_t ctrl_i,
  input  logic                valid_i,
  input  spq_pkg::entry_t     new_i,
  input  spq_pkg::entry_t     left_i,
  input  spq_pkg::entry_t     right_i,
  input  logic                left_go_i,
  output logic                go_o,
  output spq_pkg::entry_t     entry_o
);
  import spq_pkg::*;

  entry_t entry_q, entry_d;

  // The new word belongs at or ahead of this cell when the cell is empty or
  // holds a key not smaller than the new one, so equal keys come out LIFO.
  assign go_o = !valid_i || (new_i.key <= entry_q.key);

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins) begin
      if (go_o) begin
        entry_d = left_go_i ? left_i : new_i;
      end
    end else if (ctrl_i.rem) begin
      entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

@@ hw/rtl/sorted_priority_queue.sv @@
// Sorted minimum-priority queue built as a chain of compare-and-shift cells.
// Command channel: a word (mode_i, priority_req_i, payload_i) is taken at a
// rising edge where start is high and busy is low. Mode insert places the
// entry in key order, ahead of stored entries with an equal key; mode remove
// returns the entry with the smallest key; mode clear empties the queue; the
// unused mode code changes nothing.
// Every accepted word yields exactly one result word in the next cycle: done_o
// is high for a single cycle with status_o, out_priority_o, out_payload_o
// and out_count_o. The receiver cannot stall, so the result must be taken in
// that cycle. A word may be issued every cycle: every cell compares the new
// key against its own entry in parallel and shifts in the same edge, so busy
// stays low.
// An insert into a full queue is dropped with status full; a remove on an
// empty queue reports status empty. Priority and payload outputs are zero
// unless a remove succeeds. out_count_o is the entry count in seven bits.
// Reset clears the count and the result strobe; the cell contents are not
// reset since only cells below the count are ever read.
module sorted_priority_queue #(
  parameter int unsigned QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [spq_pkg::MODE_W-1:0]      mode_i,
  input  logic [spq_pkg::KEY_W-1:0]       priority_req_i,
  input  logic [spq_pkg::TAG_W-1:0]       payload_i,
  output logic                            done_o,
  output logic [spq_pkg::STATUS_W-1:0]    status_o,
  output logic [spq_pkg::KEY_W-1:0]       out_priority_o,
  output logic [spq_pkg::TAG_W-1:0]       out_payload_o,
  output logic [spq_pkg::COUNT_OUT_W-1:0] out_count_o
);
  import spq_pkg::*;

  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  logic                accept;
  mode_e               mode;
  logic                full;
  logic                empty;
  logic [CW-1:0]       count_q, count_d;
  cell_ctrl_t          ctrl;
  entry_t              new_entry;
  entry_t              cell_entry [QUEUE_DEPTH];
  logic                cell_go    [QUEUE_DEPTH];

  logic                done_q, done_d;
  status_e             status_q, status_d;
  logic [KEY_W-1:0]    pri_q, pri_d;
  logic [TAG_W-1:0]    pay_q, pay_d;
  logic [CW+COUNT_OUT_W-1:0] count_wide;

  // Every operation completes in the cycle it is accepted.
  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign mode   = mode_e'(mode_i);
  assign full   = (count_q == CW'(QUEUE_DEPTH));
  assign empty  = (count_q == '0);

  assign new_entry.key = priority_req_i;
  assign new_entry.tag = payload_i;

  // Command decode: the count is kept here and each cell derives its
  // occupancy from it.
  always_comb begin
    count_d  = count_q;
    ctrl     = '0;
    status_d = ST_OK;
    pri_d    = '0;
    pay_d    = '0;
    done_d   = accept;
    if (accept) begin
      unique case (mode)
        MODE_INSERT: begin
          if (full) begin
            status_d = ST_FULL;
          end else begin
            ctrl.ins = 1'b1;
            count_d  = count_q + CW'(1);
          end
        end
        MODE_REMOVE: begin
          if (empty) begin
            status_d = ST_EMPTY;
          end else begin
            ctrl.rem = 1'b1;
            pri_d    = cell_entry[0].key;
            pay_d    = cell_entry[0].tag;
            count_d  = count_q - CW'(1);
          end
        end
        MODE_CLEAR: begin
          count_d = '0;
        end
        default: begin
          count_d = count_q;
        end
      endcase
    end
  end

  // The cell chain: each cell trades with its left neighbor on insert and
  // its right neighbor on remove.
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    entry_t left_entry;
    entry_t right_entry;
    logic   left_go;
    if (i == 0) begin : g_head
      assign left_entry = new_entry;
      assign left_go    = 1'b0;
    end else begin : g_body
      assign left_entry = cell_entry[i-1];
      assign left_go    = cell_go[i-1];
    end
    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign right_entry = cell_entry[i];
    end else begin : g_mid
      assign right_entry = cell_entry[i+1];
    end

    spq_cell u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (ctrl),
      .valid_i   (CW'(i) < count_q),
      .new_i     (new_entry),
      .left_i    (left_entry),
      .right_i   (right_entry),
      .left_go_i (left_go),
      .go_o      (cell_go[i]),
      .entry_o   (cell_entry[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      done_q   <= 1'b0;
      status_q <= ST_OK;
    end else begin
      count_q  <= count_d;
      done_q   <= done_d;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pri_q <= pri_d;
    pay_q <= pay_d;
  end

  // The count register already holds the value after the reported word.
  assign count_wide     = {{COUNT_OUT_W{1'b0}}, count_q};
  assign done_o         = done_q;
  assign status_o       = status_q;
  assign out_priority_o = pri_q;
  assign out_payload_o  = pay_q;
  assign out_count_o    = count_wide[COUNT_OUT_W-1:0];

endmodule

@@ hw/rtl/spq_checker.sv @@
module spq_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            start,
  input logic                            busy,
  input logic [spq_pkg::MODE_W-1:0]      mode_i,
  input logic                            done_o,
  input logic [spq_pkg::STATUS_W-1:0]    status_o,
  input logic [spq_pkg::KEY_W-1:0]       out_priority_o,
  input logic [spq_pkg::TAG_W-1:0]       out_payload_o,
  input logic [spq_pkg::COUNT_OUT_W-1:0] out_count_o
);
  import spq_pkg::*;

  // Each accepted word gives exactly one result in the next cycle.
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) |-> (done_o == $past(start && !busy)))
    else $error("result strobe does not follow accepted word");

  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_EMPTY) |-> (out_count_o == '0))
    else $error("empty status with nonzero count");

  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != ST_OK) |-> (out_priority_o == '0 && out_payload_o == '0))
    else $error("error result carries data");

  a_full_on_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(rst_ni) && status_o == ST_FULL) |-> ($past(mode_i) == MODE_INSERT))
    else $error("full status for a word that was not an insert");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(rst_ni) && $past(mode_i) == MODE_CLEAR) |-> (out_count_o == '0))
    else $error("clear left entries in the queue");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (.*);

@@ sim/sorted_priority_queue_tb.sv @@
`timescale 1ns / 100ps

module sorted_priority_queue_tb;
  import spq_pkg::*;

  localparam int unsigned DEPTH        = QUEUE_DEPTH_DEF;
  localparam int unsigned RANDOM_WORDS = 1000;
  // Any stretch this long without a word going in or a result coming out is a hang.
  localparam int unsigned STALL_LIMIT  = 2000;
  // Cycles waited after the last awaited result, to catch stray results.
  localparam int unsigned TAIL_CYCLES  = 4;
  // The fourth mode code is not decoded by the block and must change nothing.
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam logic [KEY_W-1:0]  KEY_MAX     = {KEY_W{1'b1}};
  localparam logic [TAG_W-1:0]  TAG_MAX     = {TAG_W{1'b1}};

  // One result word as the queue reports it.
  typedef struct packed {
    status_e                status;
    logic [KEY_W-1:0]       pri;
    logic [TAG_W-1:0]       pay;
    logic [COUNT_OUT_W-1:0] count;
  } outcome_t;

  // One row of the directed table. A row with reps above one sends the same
  // word several times, the payload stepping by one each time. Where
  // typed is set the outcome is written into the row; otherwise the
  // queue model decides it.
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [KEY_W-1:0]  key;
    logic [TAG_W-1:0]  tag;
    logic [7:0]        reps;
    logic              typed;
    outcome_t          outcome;
  } stim_row_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   start;
  logic                   busy;
  logic [MODE_W-1:0]      mode_i;
  logic [KEY_W-1:0]       priority_req_i;
  logic [TAG_W-1:0]       payload_i;
  logic                   done_o;
  logic [STATUS_W-1:0]    status_o;
  logic [KEY_W-1:0]       out_priority_o;
  logic [TAG_W-1:0]       out_payload_o;
  logic [COUNT_OUT_W-1:0] out_count_o;

  sorted_priority_queue #(
    .QUEUE_DEPTH(DEPTH)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .mode_i        (mode_i),
    .priority_req_i(priority_req_i),
    .payload_i     (payload_i),
    .done_o        (done_o),
    .status_o      (status_o),
    .out_priority_o(out_priority_o),
    .out_payload_o (out_payload_o),
    .out_count_o   (out_count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Shadow copy of the queue: keys ascending from slot zero, payloads
  // alongside, and the number of slots in use.
  logic [KEY_W-1:0] shadow_keys [DEPTH];
  logic [TAG_W-1:0] shadow_tags [DEPTH];
  int unsigned      shadow_count;

  // Outcomes of accepted words whose result has not yet been seen.
  outcome_t    awaited_results[$];
  int unsigned mismatch_count;
  int unsigned results_seen;
  int unsigned quiet_cycles;

  // Applies one word to the shadow queue and returns the result it must give.
  function automatic outcome_t predict_outcome(input logic [MODE_W-1:0] m,
                                               input logic [KEY_W-1:0] k,
                                               input logic [TAG_W-1:0] t);
    outcome_t    res;
    int unsigned pos;
    res = '{status: ST_OK, pri: '0, pay: '0, count: '0};
    if (m == MODE_INSERT) begin
      if (shadow_count >= DEPTH) begin
        res.status = ST_FULL;
      end else begin
        // A new key lands in front of every stored key equal to it, so ties
        // come back out newest first.
        pos = 0;
        while (pos < shadow_count && k > shadow_keys[pos]) pos++;
        for (int i = shadow_count; i > pos; i--) begin
          shadow_keys[i] = shadow_keys[i-1];
          shadow_tags[i] = shadow_tags[i-1];
        end
        shadow_keys[pos] = k;
        shadow_tags[pos] = t;
        shadow_count++;
      end
    end else if (m == MODE_REMOVE) begin
      if (shadow_count == 0) begin
        res.status = ST_EMPTY;
      end else begin
        res.pri = shadow_keys[0];
        res.pay = shadow_tags[0];
        for (int i = 1; i < shadow_count; i++) begin
          shadow_keys[i-1] = shadow_keys[i];
          shadow_tags[i-1] = shadow_tags[i];
        end
        shadow_count--;
      end
    end else if (m == MODE_CLEAR) begin
      shadow_count = 0;
    end
    res.count = shadow_count[COUNT_OUT_W-1:0];
    return res;
  endfunction

  task automatic flag_mismatch(input string field, input logic [31:0] got,
                               input logic [31:0] want);
    $display("[%0t] result %0d: %s is 0x%0h, expected 0x%0h",
             $realtime, results_seen, field, got, want);
    mismatch_count++;
  endtask

  // Drives one command word from a falling edge and holds it until the block
  // takes it. The expectation is filed at the edge where the word is taken.
  task automatic send_word(input logic [MODE_W-1:0] m, input logic [KEY_W-1:0] k,
                           input logic [TAG_W-1:0] t, input logic typed,
                           input outcome_t typed_outcome);
    outcome_t res;
    @(negedge clk_i);
    start          <= 1'b1;
    mode_i         <= m;
    priority_req_i <= k;
    payload_i      <= t;
    @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);
    res = predict_outcome(m, k, t);
    if (typed) res = typed_outcome;
    awaited_results.push_back(res);
  endtask

  // Leaves the command channel empty for a number of cycles.
  task automatic hold_off(input int unsigned cycles);
    @(negedge clk_i);
    start <= 1'b0;
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  task automatic maybe_idle(input bit quiet);
    if (!quiet && $urandom_range(0, 99) < 17) hold_off($urandom_range(1, 5));
  endtask

  // Key domains: a handful of small values so that ties are common, the
  // whole range, and the corners of the range.
  function automatic logic [KEY_W-1:0] pick_key(input int unsigned domain);
    logic [31:0] raw;
    raw = $urandom();
    case (domain)
      0: pick_key = KEY_W'($urandom_range(0, 7));
      1: pick_key = raw[KEY_W-1:0];
      default: begin
        case (raw[1:0])
          2'd0: pick_key = '0;
          2'd1: pick_key = KEY_MAX;
          2'd2: pick_key = 24'h800000;
          default: pick_key = 24'h7FFFFF;
        endcase
      end
    endcase
  endfunction

  function automatic stim_row_t make_row(input logic [MODE_W-1:0] m,
                                         input logic [KEY_W-1:0] k,
                                         input logic [TAG_W-1:0] t,
                                         input int unsigned reps, input logic typed,
                                         input status_e st, input logic [KEY_W-1:0] pri,
                                         input logic [TAG_W-1:0] pay,
                                         input int unsigned count);
    make_row = '{mode: m, key: k, tag: t, reps: reps[7:0], typed: typed,
                 outcome: '{status: st, pri: pri, pay: pay,
                            count: count[COUNT_OUT_W-1:0]}};
  endfunction

  // Every result is checked at the rising edge that ends its strobe cycle,
  // against the oldest outcome still awaited.
  always @(posedge clk_i) begin
    outcome_t want;
    if (rst_ni) begin
      if (done_o === 1'b1) begin
        results_seen++;
        if (awaited_results.size() == 0) begin
          $display("[%0t] result %0d arrived with no command word outstanding",
                   $realtime, results_seen);
          mismatch_count++;
        end else begin
          want = awaited_results.pop_front();
          if (status_o !== want.status)
            flag_mismatch("status", 32'(status_o), 32'(want.status));
          if (out_priority_o !== want.pri)
            flag_mismatch("out_priority", 32'(out_priority_o), 32'(want.pri));
          if (out_payload_o !== want.pay)
            flag_mismatch("out_payload", 32'(out_payload_o), 32'(want.pay));
          if (out_count_o !== want.count)
            flag_mismatch("out_count", 32'(out_count_o), 32'(want.count));
        end
      end else if (done_o !== 1'b0) begin
        $display("[%0t] done_o is unknown", $realtime);
        mismatch_count++;
      end
    end
  end

  // Watchdog: counts cycles in which no word is taken and no result shows.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && busy === 1'b0) || done_o === 1'b1) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("[%0t] no progress for %0d cycles", $realtime, STALL_LIMIT);
        $display("** sorted_priority_queue: FAILED **");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    stim_row_t   plan[21];
    int unsigned random_sent;
    int unsigned style;
    int unsigned domain;
    int unsigned burst_len;
    int unsigned insert_pct;
    int unsigned roll;
    logic [MODE_W-1:0] m;
    logic [31:0]       raw_tag;

    rst_ni         <= 1'b0;
    start          <= 1'b0;
    mode_i         <= MODE_INSERT;
    priority_req_i <= '0;
    payload_i      <= '0;
    shadow_count   = 0;
    mismatch_count = 0;
    results_seen   = 0;
    quiet_cycles   = 0;

    // Directed part. Typed rows can be read straight off the queue contents:
    // the empty queue right after reset, the corner keys, the tie order and
    // the full and empty flags.
    plan[0]  = make_row(MODE_REMOVE, '0, '0, 1, 1, ST_EMPTY, '0, '0, 0);
    plan[1]  = make_row(MODE_CLEAR, '0, '0, 1, 1, ST_OK, '0, '0, 0);
    plan[2]  = make_row(MODE_UNUSED, KEY_MAX, TAG_MAX, 1, 1, ST_OK, '0, '0, 0);
    plan[3]  = make_row(MODE_INSERT, KEY_MAX, TAG_MAX, 1, 1, ST_OK, '0, '0, 1);
    plan[4]  = make_row(MODE_INSERT, '0, '0, 1, 1, ST_OK, '0, '0, 2);
    // An equal key goes ahead of the one already stored.
    plan[5]  = make_row(MODE_INSERT, '0, 16'h1234, 1, 1, ST_OK, '0, '0, 3);
    plan[6]  = make_row(MODE_REMOVE, '0, '0, 1, 1, ST_OK, '0, 16'h1234, 2);
    plan[7]  = make_row(MODE_REMOVE, KEY_MAX, TAG_MAX, 1, 1, ST_OK, '0, '0, 1);
    plan[8]  = make_row(MODE_REMOVE, '0, '0, 1, 1, ST_OK, KEY_MAX, TAG_MAX, 0);
    plan[9]  = make_row(MODE_INSERT, 24'h800000, 16'hAAAA, 1, 1, ST_OK, '0, '0, 1);
    plan[10] = make_row(MODE_INSERT, 24'h7FFFFF, 16'h5555, 1, 1, ST_OK, '0, '0, 2);
    plan[11] = make_row(MODE_UNUSED, '0, '0, 1, 1, ST_OK, '0, '0, 2);
    plan[12] = make_row(MODE_REMOVE, '0, '0, 1, 0, ST_OK, '0, '0, 0);
    plan[13] = make_row(MODE_CLEAR, KEY_MAX, TAG_MAX, 1, 1, ST_OK, '0, '0, 0);
    plan[14] = make_row(MODE_REMOVE, KEY_MAX, TAG_MAX, 1, 1, ST_EMPTY, '0, '0, 0);
    // Fill the queue with one repeated key, then push one more into it.
    plan[15] = make_row(MODE_INSERT, 24'h123456, 16'h0100, DEPTH, 0, ST_OK, '0, '0, 0);
    plan[16] = make_row(MODE_INSERT, 24'h000001, 16'hBEEF, 1, 1, ST_FULL, '0, '0, DEPTH);
    plan[17] = make_row(MODE_REMOVE, '0, '0, 1, 0, ST_OK, '0, '0, 0);
    plan[18] = make_row(MODE_INSERT, '0, 16'hC0DE, 1, 0, ST_OK, '0, '0, 0);
    plan[19] = make_row(MODE_REMOVE, '0, '0, 2, 0, ST_OK, '0, '0, 0);
    plan[20] = make_row(MODE_CLEAR, '0, '0, 1, 1, ST_OK, '0, '0, 0);

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[r]) begin
      for (int i = 0; i < plan[r].reps; i++) begin
        send_word(plan[r].mode, plan[r].key, plan[r].tag + TAG_W'(i), plan[r].typed,
                  plan[r].outcome);
        maybe_idle(1'b0);
      end
    end

    // Random part, in bursts. Each burst leans toward filling, draining or
    // holding the level, and draws its keys from one domain, so the queue
    // swings between empty and full and ties occur often. A window in the
    // middle runs back to back with no gaps at all.
    random_sent = 0;
    while (random_sent < RANDOM_WORDS) begin
      style     = $urandom_range(0, 2);
      domain    = $urandom_range(0, 2);
      burst_len = $urandom_range(10, 90);
      case (style)
        0: insert_pct = 88;
        1: insert_pct = 15;
        default: insert_pct = 50;
      endcase
      for (int i = 0; i < burst_len && random_sent < RANDOM_WORDS; i++) begin
        roll = $urandom_range(0, 199);
        if (roll < 2) m = MODE_CLEAR;
        else if (roll < 5) m = MODE_UNUSED;
        else m = ($urandom_range(0, 99) < insert_pct) ? MODE_INSERT : MODE_REMOVE;
        raw_tag = $urandom();
        send_word(m, pick_key(domain), raw_tag[TAG_W-1:0], 1'b0, '0);
        random_sent++;
        maybe_idle(random_sent >= 400 && random_sent < 650);
      end
    end

    @(negedge clk_i);
    start <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("** sorted_priority_queue: PASSED **");
    end else begin
      $display("** sorted_priority_queue: FAILED **");
    end
    $finish;
  end

endmodule

@@ sorted_priority_queue.f @@
hw/rtl/spq_pkg.sv
hw/rtl/spq_cell.sv
hw/rtl/sorted_priority_queue.sv
hw/rtl/spq_checker.sv
sim/sorted_priority_queue_tb.sv
